@@ rtl/xgcd_pkg.sv @@
package xgcd_pkg;

    // default signed word width; operands are one bit narrower
    localparam int DEFAULT_OPERAND_WIDTH = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_ALIGN,
        ST_DIVIDE,
        ST_UPDATE
    } xgcd_state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;     // take a new request
        logic setup;    // prepare one euclid step
        logic shift;    // double the aligned divisor
        logic step;     // one quotient bit
        logic update;   // shift the remainder sequence along
    } xgcd_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic rcur_zero;    // current remainder is zero, result ready
        logic align_more;   // divisor can still be doubled
        logic count_zero;   // last quotient bit in progress
    } xgcd_status_t;

endpackage

@@ rtl/xgcd_ctrl.sv @@
module xgcd_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  xgcd_pkg::xgcd_status_t status,
    output xgcd_pkg::xgcd_cmd_t    cmd,
    output logic                  busy,
    output logic                  done
);

    xgcd_pkg::xgcd_state_t state_reg;
    xgcd_pkg::xgcd_state_t state_next;
    logic                  done_reg;
    logic                  done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= xgcd_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd        = '0;
        case (state_reg)
            xgcd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = xgcd_pkg::ST_TEST;
                end
            end
            xgcd_pkg::ST_TEST:
            begin
                if (status.rcur_zero)
                begin
                    done_next  = 1'b1;
                    state_next = xgcd_pkg::ST_IDLE;
                end
                else
                begin
                    cmd.setup  = 1'b1;
                    state_next = xgcd_pkg::ST_ALIGN;
                end
            end
            xgcd_pkg::ST_ALIGN:
            begin
                if (status.align_more)
                begin
                    cmd.shift = 1'b1;
                end
                else
                begin
                    state_next = xgcd_pkg::ST_DIVIDE;
                end
            end
            xgcd_pkg::ST_DIVIDE:
            begin
                cmd.step = 1'b1;
                if (status.count_zero)
                begin
                    state_next = xgcd_pkg::ST_UPDATE;
                end
            end
            xgcd_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = xgcd_pkg::ST_TEST;
            end
            default:
            begin
                state_next = xgcd_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != xgcd_pkg::ST_IDLE);
    assign done = done_reg;

endmodule

@@ rtl/xgcd_datapath.sv @@
module xgcd_datapath #(
    parameter int OPERAND_WIDTH = xgcd_pkg::DEFAULT_OPERAND_WIDTH
) (
    input  logic                          clk,
    input  xgcd_pkg::xgcd_cmd_t           cmd,
    input  logic [OPERAND_WIDTH-2:0]      operand_a,
    input  logic [OPERAND_WIDTH-2:0]      operand_b,
    output xgcd_pkg::xgcd_status_t        status,
    output logic [OPERAND_WIDTH-2:0]      divisor,
    output logic signed [OPERAND_WIDTH-1:0] coeff_a,
    output logic signed [OPERAND_WIDTH-1:0] coeff_b
);

    localparam int RW = OPERAND_WIDTH - 1;
    localparam int CW = OPERAND_WIDTH;
    localparam int KW = $clog2(OPERAND_WIDTH - 1);

    logic [RW-1:0] r_prev_reg;
    logic [RW-1:0] r_cur_reg;
    logic [CW-1:0] s_prev_reg;
    logic [CW-1:0] s_cur_reg;
    logic [CW-1:0] t_prev_reg;
    logic [CW-1:0] t_cur_reg;
    logic [RW-1:0] rem_reg;
    logic [RW-1:0] d_reg;
    logic [KW-1:0] k_reg;
    logic [CW-1:0] acc_s_reg;
    logic [CW-1:0] acc_t_reg;

    logic [CW-1:0] d_dbl;
    logic          q_bit;
    logic [CW-1:0] acc_s_next;
    logic [CW-1:0] acc_t_next;

    // doubled divisor against the dividend, one bit wider to avoid overflow
    assign d_dbl = {d_reg, 1'b0};
    assign q_bit = (rem_reg >= d_reg);
    // horner form of q * s_cur and q * t_cur, msb first, modulo 2^w
    assign acc_s_next = {acc_s_reg[CW-2:0], 1'b0} + (q_bit ? s_cur_reg : '0);
    assign acc_t_next = {acc_t_reg[CW-2:0], 1'b0} + (q_bit ? t_cur_reg : '0);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            r_prev_reg <= operand_a;
            r_cur_reg  <= operand_b;
            s_prev_reg <= CW'(1);
            s_cur_reg  <= '0;
            t_prev_reg <= '0;
            t_cur_reg  <= CW'(1);
        end
        if (cmd.setup)
        begin
            rem_reg   <= r_prev_reg;
            d_reg     <= r_cur_reg;
            k_reg     <= '0;
            acc_s_reg <= '0;
            acc_t_reg <= '0;
        end
        if (cmd.shift)
        begin
            d_reg <= d_reg << 1;
            k_reg <= k_reg + KW'(1);
        end
        if (cmd.step)
        begin
            if (q_bit)
            begin
                rem_reg <= rem_reg - d_reg;
            end
            acc_s_reg <= acc_s_next;
            acc_t_reg <= acc_t_next;
            d_reg     <= d_reg >> 1;
            k_reg     <= k_reg - KW'(1);
        end
        if (cmd.update)
        begin
            r_prev_reg <= r_cur_reg;
            r_cur_reg  <= rem_reg;
            s_prev_reg <= s_cur_reg;
            s_cur_reg  <= s_prev_reg - acc_s_reg;
            t_prev_reg <= t_cur_reg;
            t_cur_reg  <= t_prev_reg - acc_t_reg;
        end
    end

    assign status.rcur_zero  = (r_cur_reg == '0);
    assign status.align_more = (d_dbl <= {1'b0, r_prev_reg});
    assign status.count_zero = (k_reg == '0);

    assign divisor = r_prev_reg;
    assign coeff_a = s_prev_reg;
    assign coeff_b = t_prev_reg;

endmodule

@@ rtl/extended_euclid_gcd_core.sv @@
// channel   | handshake          | payload                       | direction
// ----------+--------------------+-------------------------------+----------
// request   | start, busy        | operand_a, operand_b          | in
// result    | done (one strobe)  | divisor, coeff_a, coeff_b     | out
//
// one request at a time; start is taken at an edge where busy is low
// each euclid step runs a test, an align loop that doubles the divisor, a
// shift-subtract divide loop over its quotient bits and an update; a final
// test finds the remainder zero and the registered done strobe follows
// reset clears the controller only; the datapath has no reset and keeps its result between requests
// done is high for exactly one cycle and the result ports hold while busy is low
module extended_euclid_gcd_core #(
    parameter int OPERAND_WIDTH = xgcd_pkg::DEFAULT_OPERAND_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [OPERAND_WIDTH-2:0]        operand_a,
    input  logic [OPERAND_WIDTH-2:0]        operand_b,
    output logic                            done,
    output logic [OPERAND_WIDTH-2:0]        divisor,
    output logic signed [OPERAND_WIDTH-1:0] coeff_a,
    output logic signed [OPERAND_WIDTH-1:0] coeff_b
);

    xgcd_pkg::xgcd_cmd_t    cmd;
    xgcd_pkg::xgcd_status_t status;

    // sequencer: test, align divisor, divide bit by bit, update sequence
    xgcd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // remainder and coefficient sequences, with the shared divide unit
    xgcd_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .cmd       (cmd),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .status    (status),
        .divisor   (divisor),
        .coeff_a   (coeff_a),
        .coeff_b   (coeff_b)
    );

    // the result strobe only comes once the controller is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // an accepted request always makes the block busy next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // a result is only ever given once the remainder sequence has run out
    a_done_final: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status.rcur_zero)
        else $error("result strobe with nonzero remainder");

    // divide commands never overlap with loading a new request
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !(cmd.step || cmd.update || cmd.shift || cmd.setup))
        else $error("load overlaps a datapath step");

endmodule

@@ test/extended_euclid_gcd_core_test.sv @@
module extended_euclid_gcd_core_test;

    // signed word width of the core; operands are one bit narrower
    localparam int WIDTH = xgcd_pkg::DEFAULT_OPERAND_WIDTH;

    // cycles without any request or result taken before the run is abandoned
    localparam int STALL_LIMIT = 20000;

    // quiet cycles after the last result, to catch a stray strobe
    localparam int SETTLE_CYCLES = 16;

    localparam logic [WIDTH-2:0] OPERAND_MAX = {(WIDTH-1){1'b1}};

    // adjacent fibonacci numbers give the longest remainder sequence
    localparam logic [WIDTH-2:0] FIB_HIGH = 63'd7540113804746346429;
    localparam logic [WIDTH-2:0] FIB_LOW  = 63'd4660046610375530309;

    // one result of the core
    typedef struct packed {
        logic [WIDTH-2:0] divisor;
        logic [WIDTH-1:0] coeff_a;
        logic [WIDTH-1:0] coeff_b;
    } bezout_t;

    logic                    clk;
    logic                    rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic [WIDTH-2:0]        operand_a = '0;
    logic [WIDTH-2:0]        operand_b = '0;
    logic                    done;
    logic [WIDTH-2:0]        divisor;
    logic signed [WIDTH-1:0] coeff_a;
    logic signed [WIDTH-1:0] coeff_b;

    // results still owed by the core, oldest first
    bezout_t pending_results[$];

    int error_count  = 0;
    int stall_cycles = 0;

    // when set, requests follow each other with no idle cycles
    bit no_gaps = 1'b0;

    extended_euclid_gcd_core #(
        .OPERAND_WIDTH(WIDTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .operand_a(operand_a),
        .operand_b(operand_b),
        .done     (done),
        .divisor  (divisor),
        .coeff_a  (coeff_a),
        .coeff_b  (coeff_b)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // gcd and bezout coefficients by the iterative remainder sequence;
    // coefficient arithmetic wraps at the full word width
    function automatic bezout_t bezout_predict(input logic [WIDTH-2:0] a,
                                               input logic [WIDTH-2:0] b);
        logic [WIDTH-1:0] rem_old;
        logic [WIDTH-1:0] rem_new;
        logic [WIDTH-1:0] sa_old;
        logic [WIDTH-1:0] sa_new;
        logic [WIDTH-1:0] sb_old;
        logic [WIDTH-1:0] sb_new;
        logic [WIDTH-1:0] quot;
        logic [WIDTH-1:0] tmp;
        bezout_t          res;
        rem_old = {1'b0, a};
        rem_new = {1'b0, b};
        sa_old  = WIDTH'(1);
        sa_new  = '0;
        sb_old  = '0;
        sb_new  = WIDTH'(1);
        while (rem_new != '0)
        begin
            quot    = rem_old / rem_new;
            tmp     = rem_old - quot * rem_new;
            rem_old = rem_new;
            rem_new = tmp;
            tmp     = sa_old - quot * sa_new;
            sa_old  = sa_new;
            sa_new  = tmp;
            tmp     = sb_old - quot * sb_new;
            sb_old  = sb_new;
            sb_new  = tmp;
        end
        res.divisor = rem_old[WIDTH-2:0];
        res.coeff_a = sa_old;
        res.coeff_b = sb_old;
        return res;
    endfunction

    // random operand no wider than the given number of bits
    function automatic logic [WIDTH-2:0] random_operand(input int bits);
        logic [63:0]      raw;
        logic [WIDTH-2:0] mask;
        raw  = {$urandom(), $urandom()};
        mask = OPERAND_MAX >> (WIDTH - 1 - bits);
        return raw[WIDTH-2:0] & mask;
    endfunction

    // present one request and hold it until the core takes it; start is left
    // high afterwards so that back-to-back requests never drop it
    task automatic send_request(input logic [WIDTH-2:0] a, input logic [WIDTH-2:0] b);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        operand_a <= a;
        operand_b <= b;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // taken at this edge: start was high and busy low
        pending_results.insert(pending_results.size(), bezout_predict(a, b));
    endtask

    // drop start and wait until every request has been answered
    task automatic wait_all_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // zero operands and trivial divisors
    task automatic test_degenerate_operands();
        send_request('0, '0);
        send_request(OPERAND_MAX, '0);
        send_request('0, OPERAND_MAX);
        send_request('0, 63'd1);
        send_request(63'd1, '0);
        send_request(63'd1, 63'd1);
        send_request(OPERAND_MAX, 63'd1);
        send_request(63'd1, OPERAND_MAX);
        send_request(OPERAND_MAX, OPERAND_MAX);
        wait_all_results();
    endtask

    // full-width values, long remainder sequences and wide quotients
    task automatic test_extreme_operands();
        logic [WIDTH-2:0] alt_ones;
        alt_ones = (WIDTH-1)'({(WIDTH/2){2'b01}});
        send_request(OPERAND_MAX, OPERAND_MAX - 63'd1);
        send_request(FIB_HIGH, FIB_LOW);
        send_request(FIB_LOW, FIB_HIGH);
        send_request(63'd1 << 62, 63'd1 << 61);
        send_request(63'd1 << 62, 63'd3);
        send_request(OPERAND_MAX, 63'd1 << 62);
        send_request(alt_ones, ~alt_ones);
        send_request(~alt_ones, alt_ones);
        send_request((63'd1 << 61) - 63'd1, (63'd1 << 31) - 63'd1);
        send_request(63'd240, 63'd46);
        send_request(63'd12, 63'd18);
        wait_all_results();
    endtask

    // mixed random requests: full width, short widths, shared factors,
    // multiples and near neighbours, with bursts of back-to-back requests
    task automatic test_random_operands(input int count);
        logic [WIDTH-2:0] a;
        logic [WIDTH-2:0] b;
        logic [WIDTH-2:0] swap;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                no_gaps = ~no_gaps;
            case ($urandom_range(0, 5))
                0:
                begin
                    a = random_operand(WIDTH - 1);
                    b = random_operand(WIDTH - 1);
                end
                1:
                begin
                    a = random_operand($urandom_range(1, WIDTH - 1));
                    b = random_operand($urandom_range(1, WIDTH - 1));
                end
                2:
                begin
                    // common factor of up to 20 bits
                    swap = random_operand($urandom_range(1, 20));
                    a    = swap * random_operand($urandom_range(1, WIDTH - 22));
                    b    = swap * random_operand($urandom_range(1, WIDTH - 22));
                end
                3:
                begin
                    // one operand a multiple of the other, equal now and then
                    b = random_operand($urandom_range(1, 50));
                    a = b * random_operand($urandom_range(1, 12));
                end
                4:
                begin
                    a = random_operand($urandom_range(1, 8));
                    b = random_operand($urandom_range(1, 8));
                end
                default:
                begin
                    a = random_operand(WIDTH - 1);
                    b = a - random_operand($urandom_range(1, 6));
                end
            endcase
            if ($urandom_range(0, 1) == 1)
            begin
                swap = a;
                a    = b;
                b    = swap;
            end
            send_request(a, b);
        end
        no_gaps = 1'b0;
        wait_all_results();
    endtask

    // each strobed result is checked against the oldest outstanding request
    always @(posedge clk)
    begin
        bezout_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding: divisor %0d", divisor);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (divisor !== want.divisor)
                begin
                    $error("divisor mismatch: expected %0d, got %0d",
                           want.divisor, divisor);
                    error_count++;
                end
                if (coeff_a !== want.coeff_a)
                begin
                    $error("coeff_a mismatch: expected %0d, got %0d",
                           $signed(want.coeff_a), coeff_a);
                    error_count++;
                end
                if (coeff_b !== want.coeff_b)
                begin
                    $error("coeff_b mismatch: expected %0d, got %0d",
                           $signed(want.coeff_b), coeff_b);
                    error_count++;
                end
            end
        end
    end

    // cycles since the last request or result was taken
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // watchdog
    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_degenerate_operands();
        test_extreme_operands();
        test_random_operands(280);

        // any strobe in this window has no request behind it
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
